>>> rtl/core/dtq_pkg.sv
// Shared types and codes of the deadline timer queue.
package dtq_pkg;

   localparam logic [2:0] CMD_TICK    = 3'd0;
   localparam logic [2:0] CMD_ONCE    = 3'd1;
   localparam logic [2:0] CMD_PERIOD  = 3'd2;
   localparam logic [2:0] CMD_RESTART = 3'd3;
   localparam logic [2:0] CMD_STOP    = 3'd4;

   localparam logic [15:0] MAX_WAIT_RESET = 16'd1000;

   typedef struct packed {
      logic [63:0] deadline;
      logic [31:0] period;
      logic [31:0] stamp;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MARK,
      ST_SEL,
      ST_FIRE,
      ST_NFSCAN,
      ST_NFDIFF,
      ST_NFOUT
   } state_type;

endpackage

>>> rtl/core/deadline_timer_queue_top.sv
// Top level of the deadline timer queue with its register port.
//
// Commands enter on start/req_* and are taken when start is high and busy
// is low. A tick advances time by one ms and emits one item per expiring
// slot (fired_valid set), in deadline then insertion order, followed by a
// final item with last set, status and next_fire_ms. Other commands emit
// only the final item. Each item is shown for one cycle with rsp_valid;
// the receiver cannot stall it.
// Timing: slot state lives in one memory scanned one entry per cycle.
// Every command ends with a scan for the earliest deadline. A tick first
// marks the due slots in one scan, then rescans the memory before every
// fire to pick the next slot.
// max_wait_ms sits at byte address 0 and resets to 1000; write it only
// while the block is idle. Reset deactivates every slot and clears time
// and the stamp counter; the memory needs no clearing pass.
module deadline_timer_queue_top #(
   parameter int NUM_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_cmd,
   input  logic [3:0]  req_slot_id,
   input  logic [31:0] req_duration_ms,
   output logic        rsp_valid,
   output logic        rsp_fired_valid,
   output logic [3:0]  rsp_fired_slot,
   output logic        rsp_status,
   output logic [16:0] rsp_next_fire_ms,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [15:0] max_wait_ff;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_wait_ff <= dtq_pkg::MAX_WAIT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && (csr_paddr == 3'd0)) begin
         max_wait_ff <= csr_pwdata[15:0];
      end
   end

   assign csr_prdata = (csr_paddr == 3'd0) ? {16'd0, max_wait_ff} : 32'd0;

   dtq_ctrl #(.NUM_SLOTS(NUM_SLOTS)) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_slot_id      (req_slot_id),
      .req_duration_ms  (req_duration_ms),
      .max_wait         (max_wait_ff),
      .rsp_valid        (rsp_valid),
      .rsp_fired_valid  (rsp_fired_valid),
      .rsp_fired_slot   (rsp_fired_slot),
      .rsp_status       (rsp_status),
      .rsp_next_fire_ms (rsp_next_fire_ms),
      .rsp_last         (rsp_last)
   );

endmodule

>>> rtl/core/dtq_mem.sv
// Slot memory: one write port and one read port with registered read data.
module dtq_mem #(
   parameter int DEPTH = 16,
   parameter int AW = 4
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  dtq_pkg::entry_type    wr_data,
   input  logic [AW-1:0]         rd_addr,
   output dtq_pkg::entry_type    rd_data
);

   dtq_pkg::entry_type mem [DEPTH];
   dtq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/dtq_ctrl.sv
// Sequencer of the timer queue: commands, fire scans and next-fire delay.
module dtq_ctrl #(
   parameter int NUM_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_cmd,
   input  logic [3:0]  req_slot_id,
   input  logic [31:0] req_duration_ms,
   input  logic [15:0] max_wait,
   output logic        rsp_valid,
   output logic        rsp_fired_valid,
   output logic [3:0]  rsp_fired_slot,
   output logic        rsp_status,
   output logic [16:0] rsp_next_fire_ms,
   output logic        rsp_last
);

   localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CW = IW + 1;
   localparam logic [CW-1:0] NCNT = CW'(NUM_SLOTS);

   dtq_pkg::state_type state_ff, state_in;

   logic [63:0]          now_ff, now_in;
   logic [31:0]          stamp_ff, stamp_in;
   logic [NUM_SLOTS-1:0] active_ff, active_in;
   logic [NUM_SLOTS-1:0] repeat_ff, repeat_in;
   logic [NUM_SLOTS-1:0] due_ff, due_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 pv_ff, pv_in;
   logic [IW-1:0]        pidx_ff, pidx_in;
   logic                 found_ff, found_in;
   logic [IW-1:0]        bidx_ff, bidx_in;
   dtq_pkg::entry_type   best_ff, best_in;
   logic [63:0]          diff_ff, diff_in;
   logic                 status_ff, status_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_fv_ff, rsp_fv_in;
   logic [3:0]  rsp_fs_ff, rsp_fs_in;
   logic        rsp_st_ff, rsp_st_in;
   logic [16:0] rsp_nf_ff, rsp_nf_in;
   logic        rsp_last_ff, rsp_last_in;

   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   dtq_pkg::entry_type wr_data;
   dtq_pkg::entry_type rd_data;

   logic accept;
   logic scan_done;
   logic ahead;

   dtq_mem #(.DEPTH(NUM_SLOTS), .AW(IW)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (cnt_ff[IW-1:0]),
      .rd_data (rd_data)
   );

   assign busy      = (state_ff != dtq_pkg::ST_IDLE);
   assign accept    = start && !busy;
   assign scan_done = (cnt_ff == NCNT) && !pv_ff;

   // Earlier deadline wins; on a tie the older stamp wins.
   assign ahead = (rd_data.deadline < best_ff.deadline) ||
                  ((rd_data.deadline == best_ff.deadline) &&
                   ((stamp_ff - rd_data.stamp) > (stamp_ff - best_ff.stamp)));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dtq_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (req_cmd == dtq_pkg::CMD_TICK) ? dtq_pkg::ST_MARK
                                                         : dtq_pkg::ST_NFSCAN;
            end
         end
         dtq_pkg::ST_MARK: begin
            if (scan_done) state_in = dtq_pkg::ST_SEL;
         end
         dtq_pkg::ST_SEL: begin
            if (scan_done) state_in = found_ff ? dtq_pkg::ST_FIRE : dtq_pkg::ST_NFSCAN;
         end
         dtq_pkg::ST_FIRE:   state_in = dtq_pkg::ST_SEL;
         dtq_pkg::ST_NFSCAN: begin
            if (scan_done) state_in = dtq_pkg::ST_NFDIFF;
         end
         dtq_pkg::ST_NFDIFF: state_in = dtq_pkg::ST_NFOUT;
         dtq_pkg::ST_NFOUT:  state_in = dtq_pkg::ST_IDLE;
         default:            state_in = dtq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      logic          bad;
      logic [IW-1:0] sidx;
      now_in       = now_ff;
      stamp_in     = stamp_ff;
      active_in    = active_ff;
      repeat_in    = repeat_ff;
      due_in       = due_ff;
      cnt_in       = cnt_ff;
      pv_in        = 1'b0;
      pidx_in      = cnt_ff[IW-1:0];
      found_in     = found_ff;
      bidx_in      = bidx_ff;
      best_in      = best_ff;
      diff_in      = diff_ff;
      status_in    = status_ff;
      rsp_valid_in = 1'b0;
      rsp_fv_in    = 1'b0;
      rsp_fs_in    = 4'd0;
      rsp_st_in    = 1'b0;
      rsp_nf_in    = 17'd0;
      rsp_last_in  = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = IW'(req_slot_id);
      wr_data.deadline = now_ff + {32'd0, req_duration_ms};
      wr_data.period   = req_duration_ms;
      wr_data.stamp    = stamp_ff;
      bad  = 1'b0;
      sidx = IW'(req_slot_id);

      if (state_ff == dtq_pkg::ST_MARK || state_ff == dtq_pkg::ST_SEL ||
          state_ff == dtq_pkg::ST_NFSCAN) begin
         if (cnt_ff != NCNT) begin
            cnt_in = cnt_ff + CW'(1);
            pv_in  = 1'b1;
         end
         if (scan_done) cnt_in = '0;
      end

      unique case (state_ff)
         dtq_pkg::ST_IDLE: begin
            cnt_in   = '0;
            found_in = 1'b0;
            if (accept) begin
               if (req_cmd == dtq_pkg::CMD_TICK) begin
                  now_in    = now_ff + 64'd1;
                  status_in = 1'b0;
               end else begin
                  bad = (req_cmd > dtq_pkg::CMD_STOP) ||
                        ({28'd0, req_slot_id} >= 32'(NUM_SLOTS));
                  if (!bad) begin
                     case (req_cmd)
                        dtq_pkg::CMD_ONCE: bad = active_ff[sidx];
                        dtq_pkg::CMD_PERIOD:
                           bad = active_ff[sidx] || (req_duration_ms == 32'd0);
                        dtq_pkg::CMD_RESTART:
                           bad = !active_ff[sidx] || (req_duration_ms == 32'd0);
                        default: bad = !active_ff[sidx];
                     endcase
                  end
                  status_in = bad;
                  if (!bad) begin
                     if (req_cmd == dtq_pkg::CMD_STOP) begin
                        active_in[sidx] = 1'b0;
                     end else begin
                        wr_en            = 1'b1;
                        active_in[sidx]  = 1'b1;
                        stamp_in         = stamp_ff + 32'd1;
                        if (req_cmd != dtq_pkg::CMD_RESTART) begin
                           repeat_in[sidx] = (req_cmd == dtq_pkg::CMD_PERIOD);
                        end
                        if (!((req_cmd == dtq_pkg::CMD_RESTART) ? repeat_ff[sidx]
                              : (req_cmd == dtq_pkg::CMD_PERIOD))) begin
                           wr_data.period = 32'd0;
                        end
                     end
                  end
               end
            end
         end
         dtq_pkg::ST_MARK: begin
            if (pv_ff) begin
               due_in[pidx_ff] = active_ff[pidx_ff] && (rd_data.deadline <= now_ff);
            end
         end
         dtq_pkg::ST_SEL: begin
            if (pv_ff && due_ff[pidx_ff] && (!found_ff || ahead)) begin
               found_in = 1'b1;
               bidx_in  = pidx_ff;
               best_in  = rd_data;
            end
         end
         dtq_pkg::ST_FIRE: begin
            found_in      = 1'b0;
            due_in[bidx_ff] = 1'b0;
            rsp_valid_in  = 1'b1;
            rsp_fv_in     = 1'b1;
            rsp_fs_in     = 4'(bidx_ff);
            wr_addr       = bidx_ff;
            wr_data.deadline = best_ff.deadline + {32'd0, best_ff.period};
            wr_data.period   = best_ff.period;
            wr_data.stamp    = stamp_ff;
            if (repeat_ff[bidx_ff]) begin
               wr_en    = 1'b1;
               stamp_in = stamp_ff + 32'd1;
            end else begin
               active_in[bidx_ff] = 1'b0;
            end
         end
         dtq_pkg::ST_NFSCAN: begin
            if (pv_ff && active_ff[pidx_ff] &&
                (!found_ff || (rd_data.deadline < best_ff.deadline))) begin
               found_in = 1'b1;
               best_in  = rd_data;
            end
         end
         dtq_pkg::ST_NFDIFF: begin
            diff_in = (best_ff.deadline > now_ff) ? best_ff.deadline - now_ff : 64'd0;
         end
         dtq_pkg::ST_NFOUT: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = 1'b1;
            rsp_st_in    = status_ff;
            if (found_ff) begin
               rsp_nf_in = (diff_ff > {48'd0, max_wait}) ? {1'b0, max_wait} + 17'd1
                                                         : {1'b0, diff_ff[15:0]} + 17'd1;
            end
            found_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dtq_pkg::ST_IDLE;
         now_ff       <= '0;
         stamp_ff     <= '0;
         active_ff    <= '0;
         repeat_ff    <= '0;
         due_ff       <= '0;
         cnt_ff       <= '0;
         pv_ff        <= 1'b0;
         found_ff     <= 1'b0;
         status_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         stamp_ff     <= stamp_in;
         active_ff    <= active_in;
         repeat_ff    <= repeat_in;
         due_ff       <= due_in;
         cnt_ff       <= cnt_in;
         pv_ff        <= pv_in;
         found_ff     <= found_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pidx_ff     <= pidx_in;
      bidx_ff     <= bidx_in;
      best_ff     <= best_in;
      diff_ff     <= diff_in;
      rsp_fv_ff   <= rsp_fv_in;
      rsp_fs_ff   <= rsp_fs_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_nf_ff   <= rsp_nf_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fired_valid  = rsp_fv_ff;
   assign rsp_fired_slot   = rsp_fs_ff;
   assign rsp_status       = rsp_st_ff;
   assign rsp_next_fire_ms = rsp_nf_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef SYNTH
   a_fire_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_fv_ff |-> !rsp_last_ff)
      else $error("fire item marked last");
   a_fire_found: assert property (@(posedge clock) disable iff (reset)
      state_ff == dtq_pkg::ST_FIRE |-> found_ff)
      else $error("fire without a selected slot");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted item did not start work");
   a_fire_had_due: assert property (@(posedge clock) disable iff (reset)
      state_ff == dtq_pkg::ST_FIRE |-> due_ff[bidx_ff])
      else $error("fired slot was not due");
`endif

endmodule

>>> bench/deadline_timer_queue_checker.sv
// Checker for the deadline timer queue: predicts every result and compares it.
`timescale 1ns / 100ps
module deadline_timer_queue_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [2:0]  req_cmd,
   input  logic [3:0]  req_slot_id,
   input  logic [31:0] req_duration_ms,
   input  logic        rsp_valid,
   input  logic        rsp_fired_valid,
   input  logic [3:0]  rsp_fired_slot,
   input  logic        rsp_status,
   input  logic [16:0] rsp_next_fire_ms,
   input  logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          pending,
   output int          errors
);

   typedef struct packed {
      logic        fired_valid;
      logic [3:0]  fired_slot;
      logic        status;
      logic [16:0] next_fire;
      logic        last;
   } timer_result_type;

   localparam int SLOTS = 16;
   localparam logic [2:0] CSR_MAX_WAIT = 3'd0;

   timer_result_type due_results[$];

   logic [15:0] wait_clamp;
   logic [63:0] now;
   logic [63:0] deadline [SLOTS];
   logic [31:0] period [SLOTS];
   logic        periodic [SLOTS];
   logic        armed [SLOTS];
   logic [31:0] stamp [SLOTS];
   logic [31:0] stamp_next;

   assign pending = due_results.size();

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   task automatic arm_slot(input int s, input logic [31:0] dur, input logic rep);
      deadline[s] = now + 64'(dur);
      period[s]   = rep ? dur : 32'd0;
      periodic[s] = rep;
      armed[s]    = 1'b1;
      stamp[s]    = stamp_next;
      stamp_next++;
   endtask

   // True if slot a leaves the queue before slot b.
   function automatic logic earlier(input int a, input int b);
      logic [31:0] age_a, age_b;
      if (deadline[a] != deadline[b]) return deadline[a] < deadline[b];
      age_a = stamp_next - stamp[a];
      age_b = stamp_next - stamp[b];
      return age_a > age_b;
   endfunction

   function automatic logic [16:0] next_fire_delay();
      logic        any;
      logic [63:0] best, d;
      any = 1'b0;
      best = '0;
      for (int s = 0; s < SLOTS; s++)
         if (armed[s] && (!any || deadline[s] < best)) begin
            best = deadline[s];
            any = 1'b1;
         end
      if (!any) return '0;
      d = (best > now) ? best - now : 64'd0;
      if (d > 64'(wait_clamp)) d = 64'(wait_clamp);
      return 17'(d) + 17'd1;
   endfunction

   task automatic run_command(input logic [2:0] cmd, input logic [3:0] s,
                              input logic [31:0] dur);
      logic             due [SLOTS];
      logic             found;
      int               b;
      logic             bad;
      timer_result_type r;
      bad = 1'b0;
      case (cmd)
         dtq_pkg::CMD_TICK: begin
            now++;
            for (int i = 0; i < SLOTS; i++) due[i] = armed[i] && deadline[i] <= now;
            forever begin
               found = 1'b0;
               b = 0;
               for (int i = 0; i < SLOTS; i++)
                  if (due[i] && (!found || earlier(i, b))) begin
                     b = i;
                     found = 1'b1;
                  end
               if (!found) break;
               due[b] = 1'b0;
               r = '{fired_valid: 1'b1, fired_slot: 4'(b), status: 1'b0,
                     next_fire: '0, last: 1'b0};
               due_results.push_back(r);
               if (periodic[b]) begin
                  deadline[b] += 64'(period[b]);
                  stamp[b] = stamp_next;
                  stamp_next++;
               end else begin
                  armed[b] = 1'b0;
               end
            end
         end
         dtq_pkg::CMD_ONCE: begin
            if (armed[s]) bad = 1'b1; else arm_slot(s, dur, 1'b0);
         end
         dtq_pkg::CMD_PERIOD: begin
            if (armed[s] || dur == 0) bad = 1'b1; else arm_slot(s, dur, 1'b1);
         end
         dtq_pkg::CMD_RESTART: begin
            if (!armed[s] || dur == 0) bad = 1'b1; else arm_slot(s, dur, periodic[s]);
         end
         dtq_pkg::CMD_STOP: begin
            if (!armed[s]) begin
               bad = 1'b1;
            end else begin
               armed[s] = 1'b0;
               deadline[s] = '0;
            end
         end
         default: bad = 1'b1;
      endcase
      r = '{fired_valid: 1'b0, fired_slot: '0, status: bad,
            next_fire: next_fire_delay(), last: 1'b1};
      due_results.push_back(r);
   endtask

   initial errors = 0;

   always @(posedge clock) begin
      timer_result_type want;
      if (reset) begin
         due_results.delete();
         wait_clamp = dtq_pkg::MAX_WAIT_RESET;
         now = '0;
         stamp_next = '0;
         for (int i = 0; i < SLOTS; i++) begin
            deadline[i] = '0;
            period[i] = '0;
            periodic[i] = 1'b0;
            armed[i] = 1'b0;
            stamp[i] = '0;
         end
      end else begin
         if (rsp_valid) begin
            if (due_results.size() == 0) begin
               report("unexpected result", 32'(rsp_fired_slot), 0);
            end else begin
               want = due_results.pop_front();
               if (rsp_fired_valid !== want.fired_valid)
                  report("fired_valid", 32'(rsp_fired_valid), 32'(want.fired_valid));
               if (rsp_fired_slot !== want.fired_slot)
                  report("fired_slot", 32'(rsp_fired_slot), 32'(want.fired_slot));
               if (rsp_status !== want.status)
                  report("status", 32'(rsp_status), 32'(want.status));
               if (rsp_next_fire_ms !== want.next_fire)
                  report("next_fire_ms", 32'(rsp_next_fire_ms), 32'(want.next_fire));
               if (rsp_last !== want.last)
                  report("last", 32'(rsp_last), 32'(want.last));
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == CSR_MAX_WAIT)
            wait_clamp = csr_pwdata[15:0];
         if (start && !busy)
            run_command(req_cmd, req_slot_id, req_duration_ms);
      end
   end

endmodule

>>> bench/deadline_timer_queue_top_tb.sv
// Stimulus and verdict for the deadline timer queue.
`timescale 1ns / 100ps
module deadline_timer_queue_top_tb;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_cmd = dtq_pkg::CMD_TICK;
   logic [3:0]  req_slot_id = '0;
   logic [31:0] req_duration_ms = '0;
   logic        rsp_valid, rsp_fired_valid, rsp_status, rsp_last;
   logic [3:0]  rsp_fired_slot;
   logic [16:0] rsp_next_fire_ms;
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          pending, errors;

   localparam logic [2:0] CSR_MAX_WAIT = 3'd0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   deadline_timer_queue_top uut (.*);

   deadline_timer_queue_checker checker_i (.*);

   // Presents one item and holds it until the block takes it.
   task automatic send(input logic [2:0] cmd, input logic [3:0] s, input logic [31:0] dur);
      req_cmd <= cmd;
      req_slot_id <= s;
      req_duration_ms <= dur;
      start <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic pause(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain();
      pause(1);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_max_wait(input logic [15:0] value);
      drain();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_MAX_WAIT;
      csr_pwdata <= {16'($urandom_range(0, 65535)), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly ticks and short timers so slots fire often; some noise besides.
   task automatic random_item();
      int          pick;
      logic [2:0]  cmd;
      logic [31:0] dur;
      pick = $urandom_range(0, 99);
      if (pick < 45) cmd = dtq_pkg::CMD_TICK;
      else if (pick < 60) cmd = dtq_pkg::CMD_ONCE;
      else if (pick < 75) cmd = dtq_pkg::CMD_PERIOD;
      else if (pick < 85) cmd = dtq_pkg::CMD_RESTART;
      else if (pick < 95) cmd = dtq_pkg::CMD_STOP;
      else cmd = 3'($urandom_range(5, 7));
      pick = $urandom_range(0, 9);
      if (pick < 8) dur = $urandom_range(0, 6);
      else if (pick < 9) dur = $urandom_range(0, 40);
      else dur = $urandom;
      send(cmd, 4'($urandom_range(0, 15)), dur);
   endtask

   task automatic random_burst(input int count);
      int left;
      left = count;
      while (left > 0) begin
         for (int n = $urandom_range(1, 10); n > 0 && left > 0; n--) begin
            random_item();
            left--;
         end
         if ($urandom_range(0, 9) == 0) drain();
         else if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 8));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(dtq_pkg::CMD_TICK, 0, 0);
      send(dtq_pkg::CMD_ONCE, 0, 0);
      send(dtq_pkg::CMD_TICK, 0, 0);
      send(dtq_pkg::CMD_PERIOD, 15, 0);
      send(dtq_pkg::CMD_PERIOD, 15, 1);
      send(dtq_pkg::CMD_ONCE, 15, 5);
      send(dtq_pkg::CMD_ONCE, 3, 32'hFFFF_FFFF);
      send(dtq_pkg::CMD_RESTART, 3, 2);
      send(dtq_pkg::CMD_RESTART, 15, 0);
      send(dtq_pkg::CMD_RESTART, 7, 4);
      send(dtq_pkg::CMD_STOP, 7, 0);
      send(3'd5, 1, 1);
      send(3'd6, 2, 2);
      send(3'd7, 15, 32'hFFFF_FFFF);
      // Equal deadlines leave in insertion order.
      send(dtq_pkg::CMD_ONCE, 2, 2);
      send(dtq_pkg::CMD_ONCE, 1, 2);
      send(dtq_pkg::CMD_PERIOD, 4, 2);
      pause(3);
      send(dtq_pkg::CMD_TICK, 0, 0);
      send(dtq_pkg::CMD_TICK, 0, 0);
      send(dtq_pkg::CMD_STOP, 3, 0);
      send(dtq_pkg::CMD_STOP, 15, 32'hAAAA_5555);
      send(dtq_pkg::CMD_TICK, 0, 0);
      send(dtq_pkg::CMD_ONCE, 9, 32'h8000_0000);
      send(dtq_pkg::CMD_TICK, 0, 0);
      drain();

      // Arm every slot that is free with the same deadline so one tick fires them all.
      write_max_wait(16'd0);
      for (int s = 0; s < 16; s++) send(dtq_pkg::CMD_ONCE, 4'(s), 1);
      send(dtq_pkg::CMD_TICK, 0, 0);
      send(dtq_pkg::CMD_TICK, 0, 0);
      random_burst(30);

      write_max_wait(16'd1);
      random_burst(35);
      write_max_wait(16'hFFFF);
      send(dtq_pkg::CMD_PERIOD, 5, 32'h0001_2345);
      random_burst(35);
      write_max_wait(16'($urandom_range(2, 20)));
      random_burst(35);
      write_max_wait(dtq_pkg::MAX_WAIT_RESET);
      random_burst(40);

      drain();
      repeat (40) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
